>>> hw/rtl/scb_pkg.sv
package scb_pkg;

  localparam int LINE_COLS   = 30;
  localparam int STORE_LINES = 64;
  localparam int VIEW_ROWS   = 8;

  localparam int SLOT_W   = $clog2(STORE_LINES);
  localparam int TOTAL_W  = $clog2(STORE_LINES + 1);
  localparam int LEN_W    = $clog2(LINE_COLS + 1);
  localparam int CDEPTH   = STORE_LINES * LINE_COLS;
  localparam int CADDR_W  = $clog2(CDEPTH);
  // view arithmetic widths: offset + row distance, and offset + scroll amount
  localparam int BACK_W   = $clog2(STORE_LINES + VIEW_ROWS) + 2;
  localparam int SCR_W    = ((SLOT_W > 8) ? SLOT_W : 8) + 2;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_SCROLL = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [7:0]  NEWLINE_CODE    = 8'd10;
  localparam logic [15:0] BLANK_COLOR_RST = 16'hFFFF;

  typedef struct packed {
    logic load;    // latch a new item
    logic exec;    // apply item to state, issue memory reads
    logic finish;  // read data back, form read result
  } scb_cmd_t;

  typedef struct packed {
    logic is_read;
  } scb_sts_t;

endpackage

>>> hw/rtl/scb_ram.sv
module scb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/scb_ctrl.sv
module scb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  scb_pkg::scb_sts_t sts,
  output scb_pkg::scb_cmd_t cmd,
  output logic              busy,
  output logic              out_strobe
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.is_read) begin
          state_nxt = ST_RDATA;
        end else begin
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
        end
      end
      ST_RDATA: begin
        state_nxt  = ST_IDLE;
        strobe_nxt = 1'b1;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && start;
  assign cmd.exec   = (state_r == ST_EXEC);
  assign cmd.finish = (state_r == ST_RDATA);
  assign out_strobe = strobe_r;

endmodule

>>> hw/rtl/scb_dp.sv
module scb_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  scb_pkg::scb_cmd_t            cmd,
  output scb_pkg::scb_sts_t            sts,
  input  logic [1:0]                   in_operation,
  input  logic [7:0]                   in_char_code,
  input  logic [15:0]                  in_line_color,
  input  logic                         in_end_of_text,
  input  logic [7:0]                   in_scroll_lines,
  input  logic [2:0]                   in_view_row,
  input  logic [4:0]                   in_view_column,
  input  logic                         cfg_wr_en,
  input  logic [15:0]                  cfg_blank_row_color,
  output logic [7:0]                   out_cell_char,
  output logic [15:0]                  out_cell_color,
  output logic                         out_cell_shown,
  output logic [scb_pkg::TOTAL_W-1:0]  out_stored_lines,
  output logic [scb_pkg::SLOT_W-1:0]   out_view_position,
  output logic [scb_pkg::SLOT_W-1:0]   out_next_slot
);

  localparam int SW  = scb_pkg::SLOT_W;
  localparam int TW  = scb_pkg::TOTAL_W;
  localparam int LW  = scb_pkg::LEN_W;
  localparam int CW  = scb_pkg::CADDR_W;
  localparam int BW  = scb_pkg::BACK_W;
  localparam int XW  = scb_pkg::SCR_W;

  // latched item
  logic [1:0]  op_r;
  logic [7:0]  ch_r;
  logic [15:0] color_r;
  logic        last_r;
  logic [7:0]  lines_r;
  logic [2:0]  row_r;
  logic [4:0]  col_r;

  // block state
  logic [SW-1:0] head_r, head_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [SW-1:0] off_r, off_nxt;
  logic          open_r, open_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic          swal_r, swal_nxt;
  logic [15:0]   blank_r;

  // read pipeline
  logic          rd_shown_r;
  logic          rd_colok_r;
  logic [4:0]    rd_col_r;

  logic [7:0]    out_char_r;
  logic [15:0]   out_color_r;
  logic          out_shown_r;
  logic [TW-1:0] out_total_r;
  logic [SW-1:0] out_off_r;
  logic [SW-1:0] out_head_r;

  logic          is_nl;
  logic          fin, col_we, chr_we;
  logic [LW-1:0] fin_len, fill_eff, fill_inc;
  logic [XW-1:0] limit, scr_sum;

  logic          row_ok, shown, col_ok;
  logic [BW-1:0] back;
  logic [BW:0]   slot_full;
  logic [SW-1:0] rd_slot;
  logic [4:0]    rd_col;
  logic [CW-1:0] chr_waddr, chr_raddr;

  logic [7:0]    chr_rdata;
  logic [LW-1:0] len_rdata;
  logic [15:0]   col_rdata;

  logic          out_load;

  assign is_nl       = (ch_r == scb_pkg::NEWLINE_CODE);
  assign sts.is_read = (op_r == scb_pkg::OP_READ);

  always_comb begin
    head_nxt  = head_r;
    total_nxt = total_r;
    off_nxt   = off_r;
    open_nxt  = open_r;
    fill_nxt  = fill_r;
    swal_nxt  = swal_r;
    fin       = 1'b0;
    col_we    = 1'b0;
    chr_we    = 1'b0;
    fill_eff  = fill_r;
    fill_inc  = fill_r + LW'(1);
    fin_len   = fill_r;
    limit     = (32'(total_r) > scb_pkg::VIEW_ROWS) ?
                XW'(total_r) - XW'(scb_pkg::VIEW_ROWS) : '0;
    scr_sum   = XW'(off_r) + XW'(lines_r);
    case (op_r)
      scb_pkg::OP_APPEND: begin
        if (is_nl && swal_r) begin
          swal_nxt = 1'b0;
        end else if (is_nl || (ch_r != 8'd0)) begin
          if (!open_r) begin
            // opening a line in a full ring drops the oldest one
            if (32'(total_r) >= scb_pkg::STORE_LINES) begin
              total_nxt = TW'(scb_pkg::STORE_LINES - 1);
            end
            col_we   = 1'b1;
            fill_eff = '0;
          end
          if (is_nl) begin
            fin     = 1'b1;
            fin_len = fill_eff;
          end else begin
            swal_nxt = 1'b0;
            chr_we   = 1'b1;
            fill_inc = fill_eff + LW'(1);
            if (32'(fill_inc) >= scb_pkg::LINE_COLS) begin
              fin      = 1'b1;
              fin_len  = fill_inc;
              swal_nxt = 1'b1;
              open_nxt = 1'b0;
            end else begin
              open_nxt = 1'b1;
              fill_nxt = fill_inc;
            end
          end
        end
        if (last_r) begin
          if (open_nxt && !fin) begin
            fin     = 1'b1;
            fin_len = fill_nxt;
          end
          swal_nxt = 1'b0;
          off_nxt  = '0;
        end
        if (fin) begin
          head_nxt = (32'(head_r) == scb_pkg::STORE_LINES - 1) ? '0 : head_r + SW'(1);
          if (32'(total_nxt) < scb_pkg::STORE_LINES) begin
            total_nxt = total_nxt + TW'(1);
          end
          open_nxt = 1'b0;
          fill_nxt = '0;
        end
      end
      scb_pkg::OP_SCROLL: begin
        off_nxt = (scr_sum > limit) ? SW'(limit) : SW'(scr_sum);
      end
      default: ;
    endcase
  end

  // read address: slot counted back from the newest line
  always_comb begin
    row_ok    = (32'(row_r) < scb_pkg::VIEW_ROWS);
    back      = BW'(off_r) + BW'(scb_pkg::VIEW_ROWS - 1) - BW'(row_r);
    shown     = row_ok && (back < BW'(total_r));
    slot_full = (BW + 1)'(head_r) + (BW + 1)'(scb_pkg::STORE_LINES - 1) - (BW + 1)'(back);
    if (slot_full >= (BW + 1)'(scb_pkg::STORE_LINES)) begin
      slot_full = slot_full - (BW + 1)'(scb_pkg::STORE_LINES);
    end
    rd_slot   = SW'(slot_full);
    col_ok    = (32'(col_r) < scb_pkg::LINE_COLS);
    rd_col    = col_ok ? col_r : 5'd0;
    chr_raddr = CW'(CW'(rd_slot) * CW'(scb_pkg::LINE_COLS)) + CW'(rd_col);
    chr_waddr = CW'(CW'(head_r) * CW'(scb_pkg::LINE_COLS)) + CW'(fill_eff);
  end

  scb_ram #(.WIDTH(8), .DEPTH(scb_pkg::CDEPTH)) u_chr_ram (
    .clk   (clk),
    .we    (cmd.exec && chr_we),
    .waddr (chr_waddr),
    .wdata (ch_r),
    .raddr (chr_raddr),
    .rdata (chr_rdata)
  );

  scb_ram #(.WIDTH(LW), .DEPTH(scb_pkg::STORE_LINES)) u_len_ram (
    .clk   (clk),
    .we    (cmd.exec && fin),
    .waddr (head_r),
    .wdata (fin_len),
    .raddr (rd_slot),
    .rdata (len_rdata)
  );

  scb_ram #(.WIDTH(16), .DEPTH(scb_pkg::STORE_LINES)) u_col_ram (
    .clk   (clk),
    .we    (cmd.exec && col_we),
    .waddr (head_r),
    .wdata (color_r),
    .raddr (rd_slot),
    .rdata (col_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      ch_r    <= in_char_code;
      color_r <= in_line_color;
      last_r  <= in_end_of_text;
      lines_r <= in_scroll_lines;
      row_r   <= in_view_row;
      col_r   <= in_view_column;
    end
    if (cmd.exec) begin
      rd_shown_r <= shown;
      rd_colok_r <= col_ok;
      rd_col_r   <= col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      total_r <= '0;
      off_r   <= '0;
      open_r  <= 1'b0;
      fill_r  <= '0;
      swal_r  <= 1'b0;
      blank_r <= scb_pkg::BLANK_COLOR_RST;
    end else begin
      if (cmd.exec) begin
        head_r  <= head_nxt;
        total_r <= total_nxt;
        off_r   <= off_nxt;
        open_r  <= open_nxt;
        fill_r  <= fill_nxt;
        swal_r  <= swal_nxt;
      end
      if (cfg_wr_en) begin
        blank_r <= cfg_blank_row_color;
      end
    end
  end

  assign out_load = (cmd.exec && !sts.is_read) || cmd.finish;

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd.finish && rd_shown_r) begin
        out_char_r  <= (rd_colok_r && (32'(rd_col_r) < 32'(len_rdata))) ? chr_rdata : 8'd0;
        out_color_r <= col_rdata;
        out_shown_r <= 1'b1;
      end else if (cmd.finish) begin
        out_char_r  <= 8'd0;
        out_color_r <= blank_r;
        out_shown_r <= 1'b0;
      end else begin
        out_char_r  <= 8'd0;
        out_color_r <= 16'd0;
        out_shown_r <= 1'b0;
      end
      out_total_r <= total_nxt;
      out_off_r   <= off_nxt;
      out_head_r  <= head_nxt;
    end
  end

  assign out_cell_char     = out_char_r;
  assign out_cell_color    = out_color_r;
  assign out_cell_shown    = out_shown_r;
  assign out_stored_lines  = out_total_r;
  assign out_view_position = out_off_r;
  assign out_next_slot     = out_head_r;

endmodule

>>> hw/rtl/scrollback_line_store_top.sv
// Scroll-back line store: a ring of text lines with a scrollable view.
// Input channel: drive in_* and raise start; the item is taken at a clock
// edge where start is high and busy is low. in_operation selects append
// character, scroll view up or read visible cell.
// Result channel: every item gives one result on out_*, marked by out_strobe
// for exactly one cycle. The receiver cannot stall; results are not held.
// Results: append and scroll results are registered in the execute state;
// read results also pass through the registered read of the character,
// length and color memories. An item occupies the block through the execute
// state, and for reads also the read-data state; a new item may be taken
// while the previous result is still on the output register.
// Configuration: cfg_wr_en with cfg_blank_row_color sets the color shown for
// rows that hold no line; write only while idle.
// Reset (rst_n low, synchronous): ring empty, view at bottom, blank color
// all ones. Line memories are not cleared; stored line lengths guard reads.
module scrollback_line_store_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_operation,
  input  logic [7:0]                   in_char_code,
  input  logic [15:0]                  in_line_color,
  input  logic                         in_end_of_text,
  input  logic [7:0]                   in_scroll_lines,
  input  logic [2:0]                   in_view_row,
  input  logic [4:0]                   in_view_column,
  input  logic                         cfg_wr_en,
  input  logic [15:0]                  cfg_blank_row_color,
  output logic                         out_strobe,
  output logic [7:0]                   out_cell_char,
  output logic [15:0]                  out_cell_color,
  output logic                         out_cell_shown,
  output logic [scb_pkg::TOTAL_W-1:0]  out_stored_lines,
  output logic [scb_pkg::SLOT_W-1:0]   out_view_position,
  output logic [scb_pkg::SLOT_W-1:0]   out_next_slot
);

  scb_pkg::scb_cmd_t cmd;
  scb_pkg::scb_sts_t sts;

  scb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  scb_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_operation        (in_operation),
    .in_char_code        (in_char_code),
    .in_line_color       (in_line_color),
    .in_end_of_text      (in_end_of_text),
    .in_scroll_lines     (in_scroll_lines),
    .in_view_row         (in_view_row),
    .in_view_column      (in_view_column),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_blank_row_color (cfg_blank_row_color),
    .out_cell_char       (out_cell_char),
    .out_cell_color      (out_cell_color),
    .out_cell_shown      (out_cell_shown),
    .out_stored_lines    (out_stored_lines),
    .out_view_position   (out_view_position),
    .out_next_slot       (out_next_slot)
  );

endmodule

>>> test/scrollback_line_store_checker.sv
`timescale 1ns / 1ps
module scrollback_line_store_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [7:0]                  in_char_code,
  input  logic [15:0]                 in_line_color,
  input  logic                        in_end_of_text,
  input  logic [7:0]                  in_scroll_lines,
  input  logic [2:0]                  in_view_row,
  input  logic [4:0]                  in_view_column,
  input  logic                        cfg_wr_en,
  input  logic [15:0]                 cfg_blank_row_color,
  input  logic                        out_strobe,
  input  logic [7:0]                  out_cell_char,
  input  logic [15:0]                 out_cell_color,
  input  logic                        out_cell_shown,
  input  logic [scb_pkg::TOTAL_W-1:0] out_stored_lines,
  input  logic [scb_pkg::SLOT_W-1:0]  out_view_position,
  input  logic [scb_pkg::SLOT_W-1:0]  out_next_slot,
  output int                          fail_count,
  output int                          pending_count
);

  localparam int SW  = scb_pkg::SLOT_W;
  localparam int TW  = scb_pkg::TOTAL_W;
  localparam int LW  = scb_pkg::LEN_W;
  localparam int CAW = scb_pkg::CADDR_W;

  typedef struct packed {
    logic [7:0]    ch;
    logic [15:0]   color;
    logic          shown;
    logic [TW-1:0] lines;
    logic [SW-1:0] view;
    logic [SW-1:0] slot;
  } cell_result_t;

  // local copy of the ring
  logic [7:0]    char_mem  [scb_pkg::CDEPTH];
  logic [LW-1:0] len_mem   [scb_pkg::STORE_LINES];
  logic [15:0]   color_mem [scb_pkg::STORE_LINES];
  int            head;
  int            total;
  int            offset;
  int            fill;
  bit            line_open;
  bit            swallow;
  logic [15:0]   blank_color;

  cell_result_t  results_due[$];

  function automatic void start_line(logic [15:0] color);
    // reopening the oldest slot drops that line right away
    if (total >= scb_pkg::STORE_LINES) total = scb_pkg::STORE_LINES - 1;
    color_mem[SW'(head)] = color;
    fill = 0;
    line_open = 1'b1;
  endfunction

  function automatic void close_line();
    len_mem[SW'(head)] = LW'(fill);
    head = (head + 1) % scb_pkg::STORE_LINES;
    if (total < scb_pkg::STORE_LINES) total++;
    line_open = 1'b0;
    fill = 0;
  endfunction

  function automatic cell_result_t predict_cell_result(
    logic [1:0] op, logic [7:0] ch, logic [15:0] color, logic eot,
    logic [7:0] scroll, logic [2:0] row, logic [4:0] col);
    cell_result_t r;
    int lim;
    int back;
    int slot;
    r = '0;
    case (op)
      scb_pkg::OP_APPEND: begin
        if (ch == scb_pkg::NEWLINE_CODE) begin
          if (swallow) begin
            swallow = 1'b0;
          end else begin
            if (!line_open) start_line(color);
            close_line();
          end
        end else if (ch != 8'd0) begin
          swallow = 1'b0;
          if (!line_open) start_line(color);
          char_mem[CAW'(head * scb_pkg::LINE_COLS + fill)] = ch;
          fill++;
          if (fill >= scb_pkg::LINE_COLS) begin
            close_line();
            swallow = 1'b1;
          end
        end
        if (eot) begin
          if (line_open) close_line();
          swallow = 1'b0;
          offset = 0;
        end
      end
      scb_pkg::OP_SCROLL: begin
        lim = (total > scb_pkg::VIEW_ROWS) ? total - scb_pkg::VIEW_ROWS : 0;
        offset = offset + int'(scroll);
        if (offset > lim) offset = lim;
      end
      scb_pkg::OP_READ: begin
        r.color = blank_color;
        back = offset + (scb_pkg::VIEW_ROWS - 1 - int'(row));
        if (int'(row) < scb_pkg::VIEW_ROWS && back < total) begin
          slot = (head + scb_pkg::STORE_LINES - 1 - back) % scb_pkg::STORE_LINES;
          if (int'(col) < int'(len_mem[SW'(slot)]) && int'(col) < scb_pkg::LINE_COLS)
            r.ch = char_mem[CAW'(slot * scb_pkg::LINE_COLS + int'(col))];
          r.color = color_mem[SW'(slot)];
          r.shown = 1'b1;
        end
      end
      default: ;
    endcase
    r.lines = TW'(total);
    r.view  = SW'(offset);
    r.slot  = SW'(head);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst_n) begin
      head = 0;
      total = 0;
      offset = 0;
      fill = 0;
      line_open = 1'b0;
      swallow = 1'b0;
      blank_color = scb_pkg::BLANK_COLOR_RST;
      results_due.delete();
    end else begin
      if (cfg_wr_en) blank_color = cfg_blank_row_color;
      if (out_strobe) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with no item outstanding", $time);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("cell_char", 16'(want.ch), 16'(out_cell_char));
          check_field("cell_color", want.color, out_cell_color);
          check_field("cell_shown", 16'(want.shown), 16'(out_cell_shown));
          check_field("stored_lines", 16'(want.lines), 16'(out_stored_lines));
          check_field("view_position", 16'(want.view), 16'(out_view_position));
          check_field("next_slot", 16'(want.slot), 16'(out_next_slot));
        end
      end
      if (start && !busy)
        results_due.push_back(predict_cell_result(in_operation, in_char_code,
          in_line_color, in_end_of_text, in_scroll_lines, in_view_row, in_view_column));
    end
    pending_count <= results_due.size();
  end

endmodule

>>> test/tb_scrollback_line_store_top.sv
`timescale 1ns / 1ps
module tb_scrollback_line_store_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  in_operation = scb_pkg::OP_READ;
  logic [7:0]                  in_char_code = 8'd0;
  logic [15:0]                 in_line_color = 16'd0;
  logic                        in_end_of_text = 1'b0;
  logic [7:0]                  in_scroll_lines = 8'd0;
  logic [2:0]                  in_view_row = 3'd0;
  logic [4:0]                  in_view_column = 5'd0;
  logic                        cfg_wr_en = 1'b0;
  logic [15:0]                 cfg_blank_row_color = 16'd0;
  logic                        out_strobe;
  logic [7:0]                  out_cell_char;
  logic [15:0]                 out_cell_color;
  logic                        out_cell_shown;
  logic [scb_pkg::TOTAL_W-1:0] out_stored_lines;
  logic [scb_pkg::SLOT_W-1:0]  out_view_position;
  logic [scb_pkg::SLOT_W-1:0]  out_next_slot;

  int                          checker_fails;
  int                          pending_results;
  int                          items_sent = 0;
  bit                          idle_enabled = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  scrollback_line_store_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_char_code        (in_char_code),
    .in_line_color       (in_line_color),
    .in_end_of_text      (in_end_of_text),
    .in_scroll_lines     (in_scroll_lines),
    .in_view_row         (in_view_row),
    .in_view_column      (in_view_column),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_blank_row_color (cfg_blank_row_color),
    .out_strobe          (out_strobe),
    .out_cell_char       (out_cell_char),
    .out_cell_color      (out_cell_color),
    .out_cell_shown      (out_cell_shown),
    .out_stored_lines    (out_stored_lines),
    .out_view_position   (out_view_position),
    .out_next_slot       (out_next_slot)
  );

  scrollback_line_store_checker line_store_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_char_code        (in_char_code),
    .in_line_color       (in_line_color),
    .in_end_of_text      (in_end_of_text),
    .in_scroll_lines     (in_scroll_lines),
    .in_view_row         (in_view_row),
    .in_view_column      (in_view_column),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_blank_row_color (cfg_blank_row_color),
    .out_strobe          (out_strobe),
    .out_cell_char       (out_cell_char),
    .out_cell_color      (out_cell_color),
    .out_cell_shown      (out_cell_shown),
    .out_stored_lines    (out_stored_lines),
    .out_view_position   (out_view_position),
    .out_next_slot       (out_next_slot),
    .fail_count          (checker_fails),
    .pending_count       (pending_results)
  );

  // always entered and left on a rising edge
  task automatic send_item(logic [1:0] op, logic [7:0] ch, logic [15:0] color, logic eot,
                           logic [7:0] scroll, logic [2:0] row, logic [4:0] col);
    if (idle_enabled && $urandom_range(99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_char_code <= ch;
    in_line_color <= color;
    in_end_of_text <= eot;
    in_scroll_lines <= scroll;
    in_view_row <= row;
    in_view_column <= col;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic append_char(logic [7:0] ch, logic [15:0] color, logic eot);
    send_item(scb_pkg::OP_APPEND, ch, color, eot, 8'($urandom), 3'($urandom),
              5'($urandom_range(0, 29)));
  endtask

  task automatic scroll_up(logic [7:0] n);
    send_item(scb_pkg::OP_SCROLL, 8'($urandom), 16'($urandom), 1'($urandom), n,
              3'($urandom), 5'($urandom_range(0, 29)));
  endtask

  task automatic read_cell(logic [2:0] row, logic [4:0] col);
    send_item(scb_pkg::OP_READ, 8'($urandom), 16'($urandom), 1'($urandom), 8'($urandom),
              row, col);
  endtask

  task automatic wait_quiet(int limit);
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_results != 0 && waited < limit);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_blank_color(logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_blank_row_color <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] random_char();
    int r;
    r = $urandom_range(99);
    if (r < 12) return scb_pkg::NEWLINE_CODE;
    if (r < 14) return 8'd0;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic random_burst();
    int kind;
    int n;
    logic [15:0] color;
    kind = $urandom_range(99);
    color = 16'($urandom);
    if (kind < 50) begin
      n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(15) == 0) color = 16'($urandom);
        // most texts end cleanly, some run on into the next one
        append_char(random_char(), color, i == n - 1 && $urandom_range(9) != 0);
      end
    end else if (kind < 60) begin
      // exactly full line, often followed by a newline that gets swallowed
      for (int i = 0; i < scb_pkg::LINE_COLS; i++)
        append_char(8'($urandom_range(11, 255)), color, 1'b0);
      if ($urandom_range(2) != 0)
        append_char(scb_pkg::NEWLINE_CODE, color, 1'($urandom_range(1)));
      if ($urandom_range(1) != 0)
        append_char(scb_pkg::NEWLINE_CODE, color, 1'($urandom_range(1)));
    end else if (kind < 80) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        read_cell(3'($urandom), ($urandom_range(1) != 0) ? 5'($urandom_range(0, 7))
                                                         : 5'($urandom_range(0, 29)));
    end else if (kind < 92) begin
      scroll_up(8'(($urandom_range(3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8)));
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) read_cell(3'($urandom), 5'($urandom_range(0, 29)));
    end else if (kind < 96) begin
      send_item(OP_UNUSED, 8'($urandom), 16'($urandom), 1'($urandom), 8'($urandom),
                3'($urandom), 5'($urandom_range(0, 29)));
    end else begin
      append_char(8'd0, color, 1'($urandom_range(1)));
      read_cell(3'($urandom), ($urandom_range(1) != 0) ? 5'd0 : 5'd29);
    end
  endtask

  initial begin
    logic [15:0] blank_choice [5];
    int goal;
    blank_choice[0] = 16'h0000;
    blank_choice[1] = 16'hFFFF;
    blank_choice[2] = 16'($urandom);
    blank_choice[3] = 16'h5AA5;
    blank_choice[4] = 16'($urandom);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty ring, newline on no open line, extreme bytes and colors
    read_cell(3'd7, 5'd0);
    append_char(scb_pkg::NEWLINE_CODE, 16'h0000, 1'b0);
    read_cell(3'd7, 5'd0);
    append_char(8'd0, 16'h1111, 1'b0);
    append_char(8'd255, 16'hFFFF, 1'b0);
    append_char(8'd1, 16'h0000, 1'b1);
    read_cell(3'd7, 5'd0);
    read_cell(3'd7, 5'd1);
    read_cell(3'd7, 5'd29);
    read_cell(3'd0, 5'd0);
    send_item(OP_UNUSED, 8'hFF, 16'hFFFF, 1'b1, 8'hFF, 3'd7, 5'd29);
    scroll_up(8'd255);
    append_char(scb_pkg::NEWLINE_CODE, 16'h1234, 1'b1);
    append_char(8'd0, 16'h4321, 1'b1);
    scroll_up(8'd0);
    read_cell(3'd6, 5'd0);
    read_cell(3'd5, 5'd0);

    for (int phase = 0; phase < 5; phase++) begin
      wait_quiet(200);
      write_blank_color(blank_choice[phase]);
      idle_enabled = (phase != 2);
      goal = items_sent + 270;
      while (items_sent < goal) random_burst();
    end

    wait_quiet(200);
    if (pending_results != 0)
      $display("%0t: %0d results never arrived", $time, pending_results);
    if (checker_fails == 0 && pending_results == 0)
      $display("tb_scrollback_line_store_top: done, clean");
    else
      $display("tb_scrollback_line_store_top: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timed out", $time);
    $display("tb_scrollback_line_store_top: done, errors");
    $finish;
  end

endmodule
